>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/hstk_pkg.sv
// Package: sizes and types for the heap sort top-k block
package hstk_pkg;
    localparam int STORE_DEPTH = 1024;
    localparam int COUNT_BITS  = 32;
    localparam int TAG_BITS    = 16;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int NUM_BITS    = $clog2(STORE_DEPTH + 1);
    localparam int MAX_EMIT    = 64;
    localparam int RANK_BITS   = 6;
    localparam int LIMIT_BITS  = 7;
    localparam logic [LIMIT_BITS-1:0] EMIT_RESET = 7'd10;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [TAG_BITS-1:0]   tag;
    } t_rec;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        t_rec                 wdata;
        logic [ADDR_BITS-1:0] raddr;
    } t_mem_req;
endpackage

>>> rtl/hstk_store.sv
// Record store: one write port, one registered read port
module hstk_store
    import hstk_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_rec     o_rdata
);
    t_rec r_mem [STORE_DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

>>> rtl/heap_sort_descending_top_k.sv
// Top level: record loading, heap sort sequencer and top-k emission
// Load: one cycle per record, busy stays low while loading.
// Sort: each sift level does up to three reads and two writes on the store, in states RDI,
//   RDL, RDR, CMP and WR2.
// Emit: outputs are registered; after the sort ends, one result a cycle, no stalls.
// Reset (i_rst_n low, synchronous): empty set, emit_limit = 10, idle.
`include "assert_macros.svh"
module heap_sort_descending_top_k
    import hstk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           i_record_count,
    input  logic [15:0]           i_record_tag,
    input  logic                  i_is_last,
    input  logic                  i_cfg_we,
    input  logic [LIMIT_BITS-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [31:0]           o_out_count,
    output logic [15:0]           o_out_tag,
    output logic [RANK_BITS-1:0]  o_out_rank,
    output logic                  o_last_of_run,
    output logic                  o_overflowed
);
    typedef enum logic [3:0] {
        S_LOAD, S_BUILD, S_RDI, S_RDL, S_RDR, S_CMP, S_WR2,
        S_EXTR, S_EXW, S_EXW2, S_ERD, S_EOUT
    } t_state;

    t_state                r_state;
    logic [NUM_BITS-1:0]   r_loaded;
    logic                  r_ovf;
    logic [LIMIT_BITS-1:0] r_limit;
    logic [NUM_BITS-1:0]   r_n;       // heap size for sift
    logic [NUM_BITS-1:0]   r_outer;   // build index / extract index
    logic                  r_phase;   // 0 build, 1 extract
    logic [NUM_BITS:0]     r_i;
    t_rec                  r_ri, r_rs, r_tmp;
    logic [NUM_BITS:0]     r_s;
    logic [RANK_BITS:0]    r_k, r_emit;
    t_mem_req              mreq;
    t_rec                  rdata;
    logic [NUM_BITS:0]     left_idx, right_idx;
    logic                  key_less;
    logic [NUM_BITS:0]     n_s;
    t_rec                  n_rs;
    logic [RANK_BITS:0]    n_emit;

    hstk_store u_store (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    assign busy      = (r_state != S_LOAD);
    assign left_idx  = {r_i[NUM_BITS-1:0], 1'b1};
    assign right_idx = left_idx + 1'b1;

    // shared key comparator: freshly read entry against the current smallest
    assign key_less = (rdata.count < r_rs.count);

    // right child folded in, and emission count for the run
    always_comb begin
        n_s  = r_s;
        n_rs = r_rs;
        if (right_idx < {1'b0, r_n} && key_less) begin
            n_s  = right_idx;
            n_rs = rdata;
        end
        n_emit = (r_limit > LIMIT_BITS'(MAX_EMIT)) ? (RANK_BITS+1)'(MAX_EMIT) : r_limit;
        if (NUM_BITS'(n_emit) > r_loaded) begin
            n_emit = (RANK_BITS+1)'(r_loaded);
        end
    end

    // store address selection
    always_comb begin
        mreq       = '0;
        mreq.raddr = r_i[ADDR_BITS-1:0];
        case (r_state)
            S_LOAD: begin
                mreq.we    = start && (r_loaded != NUM_BITS'(STORE_DEPTH));
                mreq.waddr = r_loaded[ADDR_BITS-1:0];
                mreq.wdata = {COUNT_BITS'(i_record_count), TAG_BITS'(i_record_tag)};
            end
            S_RDI:  mreq.raddr = r_i[ADDR_BITS-1:0];
            S_RDL:  mreq.raddr = left_idx[ADDR_BITS-1:0];
            S_RDR:  mreq.raddr = right_idx[ADDR_BITS-1:0];
            S_CMP: begin
                mreq.we    = (n_s != r_i);
                mreq.waddr = r_i[ADDR_BITS-1:0];
                mreq.wdata = n_rs;
            end
            S_WR2: begin
                mreq.we    = 1'b1;
                mreq.waddr = r_s[ADDR_BITS-1:0];
                mreq.wdata = r_ri;
            end
            S_EXTR: mreq.raddr = '0;
            S_EXW: begin
                mreq.raddr = ADDR_BITS'(r_outer - 1'b1);
            end
            S_EXW2: begin
                mreq.we    = 1'b1;
                mreq.waddr = '0;
                mreq.wdata = rdata;
            end
            S_ERD: begin
                mreq.we    = 1'b1;
                mreq.waddr = ADDR_BITS'(r_outer - 1'b1);
                mreq.wdata = r_tmp;
                mreq.raddr = '0;
            end
            S_EOUT: mreq.raddr = ADDR_BITS'(r_k + 1'b1);
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_loaded <= '0;
            r_ovf    <= 1'b0;
            r_limit  <= EMIT_RESET;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            o_valid <= (r_state == S_EOUT) && (r_k != r_emit);
            case (r_state)
                S_LOAD: if (start) begin
                    if (r_loaded != NUM_BITS'(STORE_DEPTH)) r_loaded <= r_loaded + 1'b1;
                    else r_ovf <= 1'b1;
                    if (i_is_last) begin
                        r_n     <= (r_loaded != NUM_BITS'(STORE_DEPTH)) ?
                                   r_loaded + 1'b1 : r_loaded;
                        r_outer <= (r_loaded != NUM_BITS'(STORE_DEPTH)) ?
                                   (r_loaded + 1'b1) >> 1 : r_loaded >> 1;
                        r_phase <= 1'b0;
                        r_state <= S_BUILD;
                    end
                end
                // next heapify root, or switch to extraction
                S_BUILD: begin
                    if (r_outer != 0) begin
                        r_i     <= {1'b0, r_outer - 1'b1};
                        r_outer <= r_outer - 1'b1;
                        r_state <= S_RDI;
                    end else begin
                        r_phase <= 1'b1;
                        r_outer <= r_n;
                        r_state <= S_EXTR;
                    end
                end
                S_RDI: r_state <= S_RDL;
                S_RDL: begin
                    r_ri <= rdata;
                    r_rs <= rdata;
                    r_s  <= r_i;
                    if (left_idx < {1'b0, r_n}) r_state <= S_RDR;
                    else r_state <= r_phase ? S_EXTR : S_BUILD;
                end
                // left child data now valid
                S_RDR: begin
                    if (key_less) begin
                        r_rs <= rdata;
                        r_s  <= left_idx;
                    end
                    r_state <= S_CMP;
                end
                // right child data now valid; parent written here if it moves
                S_CMP: begin
                    r_s <= n_s;
                    if (n_s == r_i) r_state <= r_phase ? S_EXTR : S_BUILD;
                    else r_state <= S_WR2;
                end
                S_WR2: begin
                    r_i     <= r_s;
                    r_state <= S_RDI;
                end
                // swap root with entry outer-1, then sift over outer-1
                S_EXTR: begin
                    if (r_outer != 0) r_state <= S_EXW;
                    else begin
                        r_k     <= '0;
                        r_emit  <= n_emit;
                        r_state <= S_EOUT;
                    end
                end
                S_EXW: begin
                    r_tmp   <= rdata;
                    r_state <= S_EXW2;
                end
                S_EXW2: r_state <= S_ERD;
                S_ERD: begin
                    r_n     <= r_outer - 1'b1;
                    r_outer <= r_outer - 1'b1;
                    r_i     <= '0;
                    r_state <= S_RDI;
                end
                // emit one record per cycle, next address read ahead
                S_EOUT: begin
                    if (r_k == r_emit) begin
                        r_loaded <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_LOAD;
                    end else begin
                        o_out_count   <= 32'(rdata.count);
                        o_out_tag     <= 16'(rdata.tag);
                        o_out_rank    <= r_k[RANK_BITS-1:0];
                        o_last_of_run <= (r_k + 1'b1 == r_emit);
                        o_overflowed  <= r_ovf;
                        r_k           <= r_k + 1'b1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_rank_range, i_clk, i_rst_n, o_valid, (RANK_BITS+1)'(o_out_rank) < r_emit)
    `ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, start && !busy && i_is_last, busy)
    `ASSERT_IMPLIES(a_no_out_loading, i_clk, i_rst_n, r_state == S_LOAD, !o_valid)
endmodule
